// ===== hw/rtl/ecliptic_to_equatorial_sun_top_macros.svh =====
// Assertion macros shared by the checker.
`ifndef ECLIPTIC_TO_EQUATORIAL_SUN_TOP_MACROS_SVH
`define ECLIPTIC_TO_EQUATORIAL_SUN_TOP_MACROS_SVH

// Checked only out of reset.
`define ECL2EQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ecl2eq assertion failed");

// Checked at every edge, reset included.
`define ECL2EQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ecl2eq assertion failed");

`endif

// ===== hw/rtl/ecl2eq_pkg.sv =====
`timescale 1ns / 1ps

package ecl2eq_pkg;

    localparam int FRAC_BITS = 16;

    // Binary angle: one turn is 2^32.
    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;

    // CORDIC datapath widths.
    localparam int CW = 36;
    localparam int ZW = 34;
    localparam logic signed [CW-1:0] GAIN_Q30 = 36'sd652032874;

    // Constant dividers: restoring, a few quotient bits per cell.
    localparam int DIV_BPS   = 3;
    localparam int DIV_Q_W   = 33;
    localparam int DIV_CELLS = DIV_Q_W / DIV_BPS;
    localparam int LON_NUM_W = 41;
    localparam int LON_R_W   = 10;
    localparam logic [63:0] LON_DEN = 64'd360;
    localparam int EPS_NUM_W = 62;
    localparam int EPS_R_W   = 34;
    localparam logic [63:0] EPS_DEN = 64'd8100000000;

    // Square root: one result bit per cell, radicand up to 2^60.
    localparam int SQ_W     = 62;
    localparam int SQ_CELLS = 31;
    localparam int SQ_TOP   = 60;

    // Side data of a vectoring CORDIC run.
    typedef struct packed {
        logic        spec;
        logic [31:0] res;
        logic        neg;
    } t_vec_side;

    typedef struct packed {
        t_vec_side               side;
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
    } t_vec_pre;

    // atan(2^-i) as a binary angle
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21344980;
            6:  v = 32'd10673781;
            7:  v = 32'd5336946;
            8:  v = 32'd2668507;
            9:  v = 32'd1334255;
            10: v = 32'd667128;
            11: v = 32'd333564;
            12: v = 32'd166782;
            13: v = 32'd83391;
            14: v = 32'd41696;
            15: v = 32'd20848;
            16: v = 32'd10424;
            17: v = 32'd5212;
            18: v = 32'd2606;
            19: v = 32'd1303;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ecl2eq_div_cell.sv =====
`timescale 1ns / 1ps

// One cell of a restoring divider by a constant; the low quotient bits
// shift in behind the numerator bits they replace.
module ecl2eq_div_cell #(
    parameter int          R_W = 10,
    parameter int          Q_W = 33,
    parameter int          BPS = 3,
    parameter logic [63:0] DEN = 64'd360
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [R_W-2:0]   i_rem,
    input  logic [Q_W-1:0]   i_quo,
    output logic [R_W-2:0]   o_rem,
    output logic [Q_W-1:0]   o_quo
);

    logic [R_W-2:0] n_rem;
    logic [Q_W-1:0] n_quo;
    logic [R_W-2:0] r_rem;
    logic [Q_W-1:0] r_quo;

    // BPS compare-subtract steps
    always_comb begin
        logic [R_W-1:0] t;
        int j;
        n_rem = i_rem;
        n_quo = i_quo;
        for (j = 0; j < BPS; j++) begin
            t     = {n_rem, n_quo[Q_W-1]};
            n_quo = {n_quo[Q_W-2:0], 1'b0};
            if (t >= DEN[R_W-1:0]) begin
                t        = t - DEN[R_W-1:0];
                n_quo[0] = 1'b1;
            end
            n_rem = t[R_W-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

// ===== hw/rtl/ecl2eq_cordic_cell.sv =====
`timescale 1ns / 1ps

// One CORDIC micro-rotation; rotation mode drives z to zero,
// vectoring mode drives y to zero.
module ecl2eq_cordic_cell #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [ecl2eq_pkg::CW-1:0] i_x,
    input  logic signed [ecl2eq_pkg::CW-1:0] i_y,
    input  logic signed [ecl2eq_pkg::ZW-1:0] i_z,
    output logic signed [ecl2eq_pkg::CW-1:0] o_x,
    output logic signed [ecl2eq_pkg::CW-1:0] o_y,
    output logic signed [ecl2eq_pkg::ZW-1:0] o_z
);

    localparam logic signed [ecl2eq_pkg::ZW-1:0] ATAN =
        {2'b00, ecl2eq_pkg::atan_turn(STAGE)};

    logic                             ccw;
    logic signed [ecl2eq_pkg::CW-1:0] xs, ys;
    logic signed [ecl2eq_pkg::CW-1:0] n_x, n_y, r_x, r_y;
    logic signed [ecl2eq_pkg::ZW-1:0] n_z, r_z;

    assign xs  = i_x >>> STAGE;
    assign ys  = i_y >>> STAGE;
    assign ccw = VECTOR ? !(i_y > 0) : (i_z >= 0);

    // counterclockwise step takes atan off z
    always_comb begin
        if (ccw) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== hw/rtl/ecl2eq_sqrt_cell.sv =====
`timescale 1ns / 1ps

// One step of the bit-pair integer square root; a tag word rides along.
module ecl2eq_sqrt_cell #(
    parameter int BIT_POS = 60,
    parameter int TAG_W   = 1
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [ecl2eq_pkg::SQ_W-1:0]    i_v,
    input  logic [ecl2eq_pkg::SQ_W-1:0]    i_r,
    input  logic [TAG_W-1:0]               i_tag,
    output logic [ecl2eq_pkg::SQ_W-1:0]    o_v,
    output logic [ecl2eq_pkg::SQ_W-1:0]    o_r,
    output logic [TAG_W-1:0]               o_tag
);

    localparam int W = ecl2eq_pkg::SQ_W;
    localparam logic [W-1:0] BIT_VAL = {{(W-1){1'b0}}, 1'b1} << BIT_POS;

    logic [W:0]   sum;
    logic [W-1:0] n_v, n_r, r_v, r_r;
    logic [TAG_W-1:0] r_tag;

    assign sum = {1'b0, i_r} + {1'b0, BIT_VAL};

    always_comb begin
        if ({1'b0, i_v} >= sum) begin
            n_v = i_v - sum[W-1:0];
            n_r = (i_r >> 1) + BIT_VAL;
        end else begin
            n_v = i_v;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v   <= n_v;
            r_r   <= n_r;
            r_tag <= i_tag;
        end
    end

    assign o_v   = r_v;
    assign o_r   = r_r;
    assign o_tag = r_tag;

endmodule

// ===== hw/rtl/ecliptic_to_equatorial_sun_top.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle; all stages advance together, and the
// whole pipe holds while a finished word waits under i_stall.
// Depth is set by the two constant dividers, two CORDIC chains and the
// 31-step square root chain.
// Reset (synchronous, active low) empties the pipe; no other state.
module ecliptic_to_equatorial_sun_top #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [24:0]        i_ecliptic_longitude,
    input  logic signed [24:0] i_julian_centuries,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [20:0]        o_ra_hours,
    output logic signed [21:0] o_declination,
    output logic [4:0]         o_ra_whole_hour,
    output logic [5:0]         o_ra_minute,
    output logic [5:0]         o_ra_second
);

    localparam int CW  = ecl2eq_pkg::CW;
    localparam int ZW  = ecl2eq_pkg::ZW;
    localparam int F   = ecl2eq_pkg::FRAC_BITS;
    localparam int NDC = ecl2eq_pkg::DIV_CELLS;
    localparam int QW  = ecl2eq_pkg::DIV_Q_W;
    localparam int LRW = ecl2eq_pkg::LON_R_W;
    localparam int ERW = ecl2eq_pkg::EPS_R_W;
    localparam int SW  = ecl2eq_pkg::SQ_W;
    localparam int NSQ = ecl2eq_pkg::SQ_CELLS;
    localparam int TAG_W = 96;
    localparam int LAT = 3 + NDC + 1 + CORDIC_STAGES + 1 + 3 + NSQ + 1
                         + CORDIC_STAGES + 1 + 3;
    localparam logic signed [63:0] EPS_C = 64'sd8438145120 <<< 20;
    localparam logic signed [25:0] DEC_LIM = 26'sd24 <<< F;

    logic           en;
    logic [LAT-1:0] r_vld;

    // pipe advances unless the output word is held
    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ---------------- obliquity polynomial, longitude numerator
    logic signed [49:0] n_tsq, n_tsq_sh;
    logic signed [47:0] n_m1;
    logic signed [24:0] r_t1;
    logic signed [29:0] r_t2_1;
    logic signed [47:0] r_m1_1, r_m1_2;
    logic [ecl2eq_pkg::LON_NUM_W-1:0] r_nlon1, r_nlon2, r_nlon3;
    logic signed [54:0] n_p3, n_p3_sh;
    logic signed [33:0] r_t3_2;
    logic signed [35:0] r_m2_2;
    logic signed [63:0] n_p;
    logic [63:0]        n_np;
    logic [ecl2eq_pkg::EPS_NUM_W-1:0] r_np3;

    assign n_tsq    = 50'(i_julian_centuries) * 50'(i_julian_centuries);
    assign n_tsq_sh = n_tsq >>> 20;
    assign n_m1     = 48'sd4681500 * 48'(i_julian_centuries);
    assign n_p3     = 55'(r_t2_1) * 55'(r_t1);
    assign n_p3_sh  = n_p3 >>> 20;
    assign n_p      = EPS_C - 64'(r_m1_2) + 64'(r_m2_2) - 64'sd181 * 64'(r_t3_2);
    assign n_np     = 64'(n_p <<< 8) + 64'd4050000000;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1    <= i_julian_centuries;
            r_t2_1  <= n_tsq_sh[29:0];
            r_m1_1  <= n_m1;
            r_nlon1 <= ({16'd0, i_ecliptic_longitude} << (32 - F)) + 41'd180;
            r_t3_2  <= n_p3_sh[33:0];
            r_m2_2  <= 36'(r_t2_1) * 36'sd60;
            r_m1_2  <= r_m1_1;
            r_nlon2 <= r_nlon1;
            r_np3   <= n_np[ecl2eq_pkg::EPS_NUM_W-1:0];
            r_nlon3 <= r_nlon2;
        end
    end

    // ---------------- angle to turn: divide by constants
    logic [LRW-2:0] w_lrem [NDC+1];
    logic [QW-1:0]  w_lquo [NDC+1];
    logic [ERW-2:0] w_erem [NDC+1];
    logic [QW-1:0]  w_equo [NDC+1];

    assign w_lrem[0] = {1'b0, r_nlon3[40:33]};
    assign w_lquo[0] = r_nlon3[32:0];
    assign w_erem[0] = {4'd0, r_np3[61:33]};
    assign w_equo[0] = r_np3[32:0];

    for (genvar g = 0; g < NDC; g++) begin : g_div
        ecl2eq_div_cell #(
            .R_W(LRW), .Q_W(QW), .BPS(ecl2eq_pkg::DIV_BPS), .DEN(ecl2eq_pkg::LON_DEN)
        ) u_lon (
            .i_clk(i_clk), .i_en(en),
            .i_rem(w_lrem[g]), .i_quo(w_lquo[g]),
            .o_rem(w_lrem[g+1]), .o_quo(w_lquo[g+1])
        );
        ecl2eq_div_cell #(
            .R_W(ERW), .Q_W(QW), .BPS(ecl2eq_pkg::DIV_BPS), .DEN(ecl2eq_pkg::EPS_DEN)
        ) u_eps (
            .i_clk(i_clk), .i_en(en),
            .i_rem(w_erem[g]), .i_quo(w_equo[g]),
            .o_rem(w_erem[g+1]), .o_quo(w_equo[g+1])
        );
    end

    // ---------------- rotation prep: fold to right half plane
    logic [31:0] lon_turn, eps_turn, lon_diff, eps_diff, lon_fold, eps_fold;
    logic        lon_flip, eps_flip;
    logic [1:0]  r_flip [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_lx [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_ly [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_lz [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_ex [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_ey [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_ez [CORDIC_STAGES+1];
    logic signed [ZW-1:0] r_lz0, r_ez0;

    assign lon_turn = w_lquo[NDC][31:0];
    assign eps_turn = w_equo[NDC][31:0];
    assign lon_diff = lon_turn - ecl2eq_pkg::TURN_QUARTER;
    assign eps_diff = eps_turn - ecl2eq_pkg::TURN_QUARTER;
    assign lon_flip = lon_diff < ecl2eq_pkg::TURN_HALF;
    assign eps_flip = eps_diff < ecl2eq_pkg::TURN_HALF;
    assign lon_fold = lon_flip ? lon_turn + ecl2eq_pkg::TURN_HALF : lon_turn;
    assign eps_fold = eps_flip ? eps_turn + ecl2eq_pkg::TURN_HALF : eps_turn;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lz0     <= ZW'(signed'(lon_fold));
            r_ez0     <= ZW'(signed'(eps_fold));
            r_flip[0] <= {lon_flip, eps_flip};
        end
    end

    assign w_lx[0] = ecl2eq_pkg::GAIN_Q30;
    assign w_ly[0] = '0;
    assign w_lz[0] = r_lz0;
    assign w_ex[0] = ecl2eq_pkg::GAIN_Q30;
    assign w_ey[0] = '0;
    assign w_ez[0] = r_ez0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        ecl2eq_cordic_cell #(.STAGE(g), .VECTOR(1'b0)) u_lon (
            .i_clk(i_clk), .i_en(en),
            .i_x(w_lx[g]), .i_y(w_ly[g]), .i_z(w_lz[g]),
            .o_x(w_lx[g+1]), .o_y(w_ly[g+1]), .o_z(w_lz[g+1])
        );
        ecl2eq_cordic_cell #(.STAGE(g), .VECTOR(1'b0)) u_eps (
            .i_clk(i_clk), .i_en(en),
            .i_x(w_ex[g]), .i_y(w_ey[g]), .i_z(w_ez[g]),
            .o_x(w_ex[g+1]), .o_y(w_ey[g+1]), .o_z(w_ez[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_flip[g+1] <= r_flip[g];
            end
        end
    end

    // ---------------- unfold, then products
    logic signed [CW-1:0] cl_f, sl_f, ce_f, se_f;
    logic signed [31:0]   r_cl, r_sl, r_ce, r_se;
    logic signed [63:0]   n_yp, n_sp, n_yp_sh, n_sp_sh, n_ss;
    logic signed [31:0]   r_y1, r_s1, r_cl1, r_y2, r_s2, r_cl2, r_y3, r_s3, r_cl3;
    logic [SW-1:0]        r_ss2, r_v3;

    assign cl_f = r_flip[CORDIC_STAGES][1] ? -w_lx[CORDIC_STAGES] : w_lx[CORDIC_STAGES];
    assign sl_f = r_flip[CORDIC_STAGES][1] ? -w_ly[CORDIC_STAGES] : w_ly[CORDIC_STAGES];
    assign ce_f = r_flip[CORDIC_STAGES][0] ? -w_ex[CORDIC_STAGES] : w_ex[CORDIC_STAGES];
    assign se_f = r_flip[CORDIC_STAGES][0] ? -w_ey[CORDIC_STAGES] : w_ey[CORDIC_STAGES];

    assign n_yp    = 64'(r_sl) * 64'(r_ce);
    assign n_sp    = 64'(r_se) * 64'(r_sl);
    assign n_yp_sh = n_yp >>> 30;
    assign n_sp_sh = n_sp >>> 30;
    assign n_ss    = 64'(r_s1) * 64'(r_s1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cl  <= cl_f[31:0];
            r_sl  <= sl_f[31:0];
            r_ce  <= ce_f[31:0];
            r_se  <= se_f[31:0];
            r_y1  <= n_yp_sh[31:0];
            r_s1  <= n_sp_sh[31:0];
            r_cl1 <= r_cl;
            r_ss2 <= n_ss[SW-1:0];
            r_y2  <= r_y1;
            r_s2  <= r_s1;
            r_cl2 <= r_cl1;
            // cosine term is zero once the sine reaches one
            r_v3  <= (r_ss2 >= (62'd1 << 60)) ? '0 : (62'd1 << 60) - r_ss2;
            r_y3  <= r_y2;
            r_s3  <= r_s2;
            r_cl3 <= r_cl2;
        end
    end

    // ---------------- square root chain
    logic [SW-1:0]    w_sv [NSQ+1];
    logic [SW-1:0]    w_sr [NSQ+1];
    logic [TAG_W-1:0] w_tag [NSQ+1];

    assign w_sv[0]  = r_v3;
    assign w_sr[0]  = '0;
    assign w_tag[0] = {r_y3, r_cl3, r_s3};

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        ecl2eq_sqrt_cell #(.BIT_POS(ecl2eq_pkg::SQ_TOP - 2 * g), .TAG_W(TAG_W)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_v(w_sv[g]), .i_r(w_sr[g]), .i_tag(w_tag[g]),
            .o_v(w_sv[g+1]), .o_r(w_sr[g+1]), .o_tag(w_tag[g+1])
        );
    end

    // ---------------- atan2 prep: special axes, left half plane
    function automatic ecl2eq_pkg::t_vec_pre vec_prep(input logic signed [CW-1:0] y,
                                                       input logic signed [CW-1:0] x);
        ecl2eq_pkg::t_vec_pre p;
        p.side.spec = 1'b0;
        p.side.res  = '0;
        p.side.neg  = 1'b0;
        p.x         = x;
        p.y         = y;
        if (y == 0) begin
            p.side.spec = 1'b1;
            p.side.res  = (x < 0) ? ecl2eq_pkg::TURN_HALF : 32'd0;
        end else if (x == 0) begin
            p.side.spec = 1'b1;
            p.side.res  = (y > 0) ? ecl2eq_pkg::TURN_QUARTER
                                  : ecl2eq_pkg::TURN_HALF + ecl2eq_pkg::TURN_QUARTER;
        end else if (x < 0) begin
            p.side.neg = 1'b1;
            p.x        = -x;
            p.y        = -y;
        end
        return p;
    endfunction

    logic signed [31:0] t_y, t_cl, t_s;
    ecl2eq_pkg::t_vec_pre ra_pre, dc_pre;
    ecl2eq_pkg::t_vec_pre r_ra_pre, r_dc_pre;
    ecl2eq_pkg::t_vec_side r_ra_side [CORDIC_STAGES+1];
    ecl2eq_pkg::t_vec_side r_dc_side [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_rx [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_ry [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_rz [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_dx [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_dy [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_dz [CORDIC_STAGES+1];

    assign t_y  = w_tag[NSQ][95:64];
    assign t_cl = w_tag[NSQ][63:32];
    assign t_s  = w_tag[NSQ][31:0];

    assign ra_pre = vec_prep(CW'(t_y), CW'(t_cl));
    assign dc_pre = vec_prep(CW'(t_s), CW'({1'b0, w_sr[NSQ][30:0]}));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ra_pre     <= ra_pre;
            r_dc_pre     <= dc_pre;
            r_ra_side[0] <= ra_pre.side;
            r_dc_side[0] <= dc_pre.side;
        end
    end

    assign w_rx[0] = r_ra_pre.x;
    assign w_ry[0] = r_ra_pre.y;
    assign w_rz[0] = '0;
    assign w_dx[0] = r_dc_pre.x;
    assign w_dy[0] = r_dc_pre.y;
    assign w_dz[0] = '0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
        ecl2eq_cordic_cell #(.STAGE(g), .VECTOR(1'b1)) u_ra (
            .i_clk(i_clk), .i_en(en),
            .i_x(w_rx[g]), .i_y(w_ry[g]), .i_z(w_rz[g]),
            .o_x(w_rx[g+1]), .o_y(w_ry[g+1]), .o_z(w_rz[g+1])
        );
        ecl2eq_cordic_cell #(.STAGE(g), .VECTOR(1'b1)) u_dec (
            .i_clk(i_clk), .i_en(en),
            .i_x(w_dx[g]), .i_y(w_dy[g]), .i_z(w_dz[g]),
            .o_x(w_dx[g+1]), .o_y(w_dy[g+1]), .o_z(w_dz[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ra_side[g+1] <= r_ra_side[g];
                r_dc_side[g+1] <= r_dc_side[g];
            end
        end
    end

    // ---------------- final turns
    ecl2eq_pkg::t_vec_side ra_s, dc_s;
    logic [31:0] r_ra_turn, r_dc_turn;

    assign ra_s = r_ra_side[CORDIC_STAGES];
    assign dc_s = r_dc_side[CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ra_turn <= ra_s.spec ? ra_s.res
                       : (ra_s.neg ? ecl2eq_pkg::TURN_HALF : 32'd0) + w_rz[CORDIC_STAGES][31:0];
            r_dc_turn <= dc_s.spec ? dc_s.res
                       : (dc_s.neg ? ecl2eq_pkg::TURN_HALF : 32'd0) + w_dz[CORDIC_STAGES][31:0];
        end
    end

    // ---------------- unit conversion and time split
    logic [36:0]        n_ra24;
    logic [48:0]        n_secs;
    logic signed [41:0] n_dm;
    logic signed [41:0] n_dq;
    logic signed [21:0] n_dec;
    logic [20:0]        r_ra1, r_ra2;
    logic [16:0]        r_secs1, r_secs2;
    logic signed [21:0] r_dec1, r_dec2;
    logic [35:0]        n_hp;
    logic [36:0]        n_mp;
    logic [4:0]         r_h2;
    logic [10:0]        r_tm2;
    logic [10:0]        n_min_full;
    logic [16:0]        n_sec_full;
    logic [20:0]        r_o_ra;
    logic signed [21:0] r_o_dec;
    logic [4:0]         r_o_h;
    logic [5:0]         r_o_m, r_o_s;

    assign n_ra24 = 37'(r_ra_turn) * 37'd24;
    assign n_secs = 49'(r_ra_turn) * 49'd86400;
    assign n_dm   = 42'(signed'(r_dc_turn)) * 42'sd360 + (42'sd1 <<< (31 - F));
    assign n_dq   = n_dm >>> (32 - F);

    // saturate to plus or minus 24 degrees
    always_comb begin
        if (n_dq > 42'(DEC_LIM)) begin
            n_dec = DEC_LIM[21:0];
        end else if (n_dq < -42'(DEC_LIM)) begin
            n_dec = -DEC_LIM[21:0];
        end else begin
            n_dec = n_dq[21:0];
        end
    end

    // hours and total minutes by reciprocal multiply, exact below 86400
    assign n_hp       = 36'(r_secs1) * 36'd298262;
    assign n_mp       = 37'(r_secs1) * 37'd279621;
    assign n_min_full = r_tm2 - 11'(r_h2) * 11'd60;
    assign n_sec_full = r_secs2 - 17'(r_tm2) * 17'd60;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ra1   <= n_ra24[36:32-F];
            r_secs1 <= n_secs[48:32];
            r_dec1  <= n_dec;
            r_h2    <= n_hp[34:30];
            r_tm2   <= n_mp[34:24];
            r_secs2 <= r_secs1;
            r_ra2   <= r_ra1;
            r_dec2  <= r_dec1;
            r_o_ra  <= r_ra2;
            r_o_dec <= r_dec2;
            r_o_h   <= r_h2;
            r_o_m   <= n_min_full[5:0];
            r_o_s   <= n_sec_full[5:0];
        end
    end

    assign o_ra_hours      = r_o_ra;
    assign o_declination   = r_o_dec;
    assign o_ra_whole_hour = r_o_h;
    assign o_ra_minute     = r_o_m;
    assign o_ra_second     = r_o_s;

endmodule

// ===== hw/rtl/ecl2eq_checker.sv =====
`timescale 1ns / 1ps
`include "ecliptic_to_equatorial_sun_top_macros.svh"

// Port-level checks of the converter.
module ecl2eq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [20:0]        o_ra_hours,
    input logic signed [21:0] o_declination,
    input logic [4:0]         o_ra_whole_hour,
    input logic [5:0]         o_ra_minute,
    input logic [5:0]         o_ra_second
);

    // reset empties the pipe
    `ECL2EQ_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)

    // input is held back only behind a waiting output word
    `ECL2EQ_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall))

    // held output word keeps its RA hours and declination
    `ECL2EQ_ASSERT(a_hold, i_clk, i_rst_n,
        (o_valid && i_stall) |=> (o_valid && $stable(o_ra_hours) && $stable(o_declination)))

    // time split stays in range
    `ECL2EQ_ASSERT(a_hms, i_clk, i_rst_n,
        o_valid |-> (o_ra_whole_hour < 5'd24 && o_ra_minute < 6'd60 && o_ra_second < 6'd60))

    // declination is saturated
    `ECL2EQ_ASSERT(a_dec, i_clk, i_rst_n,
        o_valid |-> (o_declination <= 22'sd1572864 && o_declination >= -22'sd1572864))

endmodule

bind ecliptic_to_equatorial_sun_top ecl2eq_checker u_ecl2eq_checker (.*);
